// ===== src/motor_feedback_unwrap_unit_defines.svh =====
// Assertion macros used by the checker file.
// Include guard keeps repeated includes harmless.
`ifndef MOTOR_FEEDBACK_UNWRAP_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_UNWRAP_UNIT_DEFINES_SVH

// Property checked outside reset.
`define MFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MFU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mfu_pkg.sv =====
// ----------------------------------------------------------------------------
// mfu_pkg
// Shared types and constants of the motor feedback unwrap unit.
// ----------------------------------------------------------------------------
package mfu_pkg;

  localparam int ID_W    = 11;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int ANGLE_W = 16;
  localparam int SPEED_W = 16;
  localparam int STEP_W  = 17;
  localparam int POS_W   = 32;
  localparam int CNT_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] ENC_COUNTS_RST = 16'd8191;
  localparam logic [ID_W-1:0]  BASE_ID_RST    = 11'h201;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENCODER_COUNTS = 2'd0,
    CFG_BASE_ID        = 2'd1
  } cfg_reg_t;

  // One classified frame on its way to the update stage
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
  } item_t;

endpackage

// ===== src/mfu_front.sv =====
// ----------------------------------------------------------------------------
// mfu_front
// Accepts frames, matches the ID window and registers the matching items.
// ----------------------------------------------------------------------------
module mfu_front import mfu_pkg::*; #(
  parameter int NUM_MOTORS = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [ID_W-1:0]  base_id,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ID_W-1:0]  frame_id,
  input  logic [BYTE_W-1:0] angle_high_byte,
  input  logic [BYTE_W-1:0] angle_low_byte,
  input  logic [BYTE_W-1:0] speed_high_byte,
  input  logic [BYTE_W-1:0] speed_low_byte,
  output logic             item_valid,
  input  logic             item_ready,
  output item_t            item
);

  logic [ID_W:0] id_diff;
  logic          id_match;
  logic          in_xfer;

  // Window check: no wrap past the top ID
  assign id_diff  = {1'b0, frame_id} - {1'b0, base_id};
  assign id_match = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NUM_MOTORS));

  assign in_ready = !item_valid || item_ready;
  assign in_xfer  = in_valid && in_ready;

  // Stage valid: only matching frames occupy it
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= id_match;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_xfer && id_match) begin
      item.idx   <= id_diff[IDX_W-1:0];
      item.angle <= {angle_high_byte, angle_low_byte};
      item.speed <= {speed_high_byte, speed_low_byte};
    end
  end

endmodule

// ===== src/mfu_queue.sv =====
// ----------------------------------------------------------------------------
// mfu_queue
// Two-entry queue between the classify stage and the update stage.
// ----------------------------------------------------------------------------
module mfu_queue import mfu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int DEPTH = 2;

  item_t      mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/mfu_back.sv =====
// ----------------------------------------------------------------------------
// mfu_back
// Per-channel unwrap: folds the angle step and accumulates the position.
// ----------------------------------------------------------------------------
module mfu_back import mfu_pkg::*; #(
  parameter int NUM_MOTORS = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CNT_W-1:0]          encoder_counts,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  item_t                     item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          motor_index,
  output logic [ANGLE_W-1:0]        angle,
  output logic signed [SPEED_W-1:0] speed,
  output logic signed [STEP_W-1:0]  step,
  output logic signed [POS_W-1:0]   total_position
);

  localparam int CH_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int DW   = STEP_W + 1;

  logic [ANGLE_W-1:0] last_angle   [NUM_MOTORS];
  logic [POS_W-1:0]   position_sum [NUM_MOTORS];

  logic [CH_W-1:0]      ch;
  logic                 take;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] half;
  logic signed [DW-1:0] period;
  logic signed [DW-1:0] folded;
  logic [STEP_W-1:0]    step_next;
  logic [POS_W-1:0]     pos_next;

  assign ch         = item.idx[CH_W-1:0];
  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  // Raw step, then fold by one period past half
  assign period = DW'($signed({1'b0, encoder_counts}));
  assign half   = DW'($signed({1'b0, encoder_counts >> 1}));
  assign diff   = $signed({2'b00, item.angle}) - $signed({2'b00, last_angle[ch]});

  always_comb begin
    if (diff < -half) begin
      folded = diff + period;
    end else if (diff > half) begin
      folded = diff - period;
    end else begin
      folded = diff;
    end
  end

  assign step_next = folded[STEP_W-1:0];
  assign pos_next  = position_sum[ch] + {{(POS_W-STEP_W){step_next[STEP_W-1]}}, step_next};

  // Channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        last_angle[k]   <= '0;
        position_sum[k] <= '0;
      end
    end else if (take) begin
      last_angle[ch]   <= item.angle;
      position_sum[ch] <= pos_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      motor_index    <= item.idx;
      angle          <= item.angle;
      speed          <= item.speed;
      step           <= step_next;
      total_position <= pos_next;
    end
  end

endmodule

// ===== src/motor_feedback_unwrap_unit.sv =====
// Path: a matching frame is registered in the classify stage, then in the
// queue, then in the update/output register; out_ready can stall it.
// Throughput: one frame per cycle while out_ready is high; the per-channel update is combinational.
// Frames outside the ID window are taken and dropped, giving no result.
// Reset: synchronous, clears all channel angles and positions to zero and
// restores encoder_counts to 8191 and base_id to 0x201.
// ----------------------------------------------------------------------------
// motor_feedback_unwrap_unit
// Multi-turn unwrap of motor encoder feedback frames.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_unit import mfu_pkg::*; #(
  parameter int NUM_MOTORS = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CNT_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ID_W-1:0]           frame_id,
  input  logic [BYTE_W-1:0]         angle_high_byte,
  input  logic [BYTE_W-1:0]         angle_low_byte,
  input  logic [BYTE_W-1:0]         speed_high_byte,
  input  logic [BYTE_W-1:0]         speed_low_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          motor_index,
  output logic [ANGLE_W-1:0]        angle,
  output logic signed [SPEED_W-1:0] speed,
  output logic signed [STEP_W-1:0]  step,
  output logic signed [POS_W-1:0]   total_position
);

  logic [CNT_W-1:0] encoder_counts;
  logic [ID_W-1:0]  base_id;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_counts <= ENC_COUNTS_RST;
      base_id        <= BASE_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENCODER_COUNTS: encoder_counts <= cfg_data;
        CFG_BASE_ID:        base_id        <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify
  mfu_front #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_front (
    .clk,
    .rst,
    .base_id,
    .in_valid,
    .in_ready,
    .frame_id,
    .angle_high_byte,
    .angle_low_byte,
    .speed_high_byte,
    .speed_low_byte,
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Decoupling queue
  mfu_queue u_queue (
    .clk,
    .rst,
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Per-channel update and result register
  mfu_back #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_back (
    .clk,
    .rst,
    .encoder_counts,
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid,
    .out_ready,
    .motor_index,
    .angle,
    .speed,
    .step,
    .total_position
  );

endmodule

// ===== src/mfu_checker.sv =====
// ----------------------------------------------------------------------------
// mfu_checker
// Port-level checks of the motor feedback unwrap unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_feedback_unwrap_unit_defines.svh"

module mfu_checker import mfu_pkg::*; #(
  parameter int NUM_MOTORS = 11
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [IDX_W-1:0]          motor_index,
  input logic [ANGLE_W-1:0]        angle,
  input logic signed [STEP_W-1:0]  step,
  input logic signed [POS_W-1:0]   total_position
);

  // A held result keeps its valid, angle, step and total position
  `MFU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(step) && $stable(total_position) && $stable(angle), "result changed while stalled")

  // Only channels inside the window are reported
  `MFU_ASSERT(a_idx_range, out_valid |-> {1'b0, motor_index} < (IDX_W+1)'(NUM_MOTORS), "motor index out of range")

  // Reset leaves no result pending
  `MFU_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result valid right after reset")

endmodule

bind motor_feedback_unwrap_unit mfu_checker #(
  .NUM_MOTORS(NUM_MOTORS)
) u_mfu_checker (
  .clk,
  .rst,
  .out_valid,
  .out_ready,
  .motor_index,
  .angle,
  .step,
  .total_position
);
